// File: rtl/mrsfe_pkg.sv
// Shared types and constants for the Modbus RTU slave frame engine.
package mrsfe_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} out_beat_t;

	// Register indexes.
	localparam logic [2:0] REG_SLAVE_ID      = 3'd0;
	localparam logic [2:0] REG_TIMING_ENABLE = 3'd1;
	localparam logic [2:0] REG_GAP_START     = 3'd2;
	localparam logic [2:0] REG_GAP_BYTE      = 3'd3;
	localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd4;
	localparam logic [2:0] REG_TICK_CEILING  = 3'd5;

	// Function codes.
	localparam logic [7:0] FC_READ_HOLD   = 8'h03;
	localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] FC_READ_WRITE  = 8'h17;

	localparam int          WBUF_DEPTH = 16;
	localparam int          RESP_WORDS = 16;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	// Request from the parser to the response unit.
	typedef struct packed {
		logic [15:0] read_start;
		logic [15:0] read_quantity;
		logic [15:0] write_start;
		logic [7:0]  word_count;
	} job_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		return x;
	endfunction

endpackage

// File: rtl/mrsfe_rx.sv
// Front part: tick timing, frame parser, receive CRC and write-word capture.
module mrsfe_rx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mrsfe_pkg::in_beat_t  in_data,
	input  logic [7:0]           slave_id,
	input  logic                 timing_enable,
	input  logic [7:0]           gap_start,
	input  logic [7:0]           gap_byte,
	input  logic [7:0]           idle_timeout,
	input  logic [7:0]           tick_ceiling,
	output logic                 job_valid,
	input  logic                 job_stall,
	output mrsfe_pkg::job_t      job,
	input  logic [3:0]           wb_addr,
	output logic [15:0]          wb_data
);
	import mrsfe_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_FCODE, PH_RS_HI, PH_RS_LO, PH_RQ_HI, PH_RQ_LO, PH_WS_HI, PH_WS_LO,
		PH_WQ_HI, PH_WQ_LO, PH_BCNT, PH_D_HI, PH_D_LO, PH_C_HI, PH_C_LO
	} phase_t;

	phase_t      phase_q;
	logic [15:0] crc_q;
	logic [7:0]  tick_q, fcode_q, wbytes_q, bidx_q, wcount_q, hold_q;
	logic [15:0] rs_q, rq_q, ws_q;
	logic        job_valid_q;
	logic [15:0] wwords_q [WBUF_DEPTH];

	logic        acc;
	logic [15:0] crc_nx;
	logic [8:0]  tick_inc;
	logic [7:0]  b;
	logic        start_ok;

	// One pending job; block input while it waits so write words stay put.
	assign in_stall  = job_valid_q;
	assign acc       = in_valid && !in_stall;
	assign b         = in_data.rx_byte;
	assign crc_nx    = crc_step(crc_q, b);
	assign tick_inc  = {1'b0, tick_q} + 9'd1;
	assign start_ok  = (!timing_enable || tick_q >= gap_start) && b == slave_id;
	assign job_valid = job_valid_q;
	assign job       = '{read_start: rs_q, read_quantity: rq_q, write_start: ws_q,
	                     word_count: wcount_q};
	assign wb_data   = wwords_q[wb_addr];

	always_ff @(posedge clk) begin
		if (acc && !in_data.req_type && phase_q == PH_D_LO
		    && !(timing_enable && tick_q > gap_byte) && wcount_q < 8'(WBUF_DEPTH))
			wwords_q[wcount_q[3:0]] <= {hold_q, b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; crc_q <= '0; tick_q <= '0; fcode_q <= '0;
			rs_q <= '0; rq_q <= '0; ws_q <= '0; wbytes_q <= '0; bidx_q <= '0;
			wcount_q <= '0; hold_q <= '0; job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && !job_stall)
				job_valid_q <= 1'b0;
			if (acc && in_data.req_type) begin
				if (tick_inc > {1'b0, tick_ceiling}) tick_q <= tick_ceiling;
				else tick_q <= tick_inc[7:0];
				if (timing_enable && phase_q != PH_IDLE
				    && ((tick_inc > {1'b0, tick_ceiling}) ? tick_ceiling : tick_inc[7:0])
				       > idle_timeout)
					phase_q <= PH_IDLE;
			end else if (acc) begin
				tick_q <= '0;
				// a matching start byte restarts the CRC
				crc_q  <= (phase_q == PH_IDLE && start_ok) ? crc_step(CRC_INIT, b) : crc_nx;
				if (phase_q == PH_IDLE) begin
					if (start_ok)
						phase_q <= PH_FCODE;
				end else if (timing_enable && tick_q > gap_byte) begin
					phase_q <= PH_IDLE;
				end else begin
					unique case (phase_q)
						PH_FCODE: begin
							fcode_q <= b;
							if (b == FC_READ_WRITE || b == FC_READ_HOLD) phase_q <= PH_RS_HI;
							else if (b == FC_WRITE_ONE || b == FC_WRITE_MULTI)
								phase_q <= PH_WS_HI;
							else phase_q <= PH_IDLE;
						end
						PH_RS_HI: begin rs_q[15:8] <= b; phase_q <= PH_RS_LO; end
						PH_RS_LO: begin rs_q[7:0] <= b; phase_q <= PH_RQ_HI; end
						PH_RQ_HI: begin rq_q[15:8] <= b; phase_q <= PH_RQ_LO; end
						PH_RQ_LO: begin
							rq_q[7:0] <= b;
							phase_q <= (fcode_q == FC_READ_WRITE) ? PH_WS_HI : PH_C_HI;
						end
						PH_WS_HI: begin ws_q[15:8] <= b; phase_q <= PH_WS_LO; end
						PH_WS_LO: begin
							ws_q[7:0] <= b;
							if (fcode_q == FC_WRITE_ONE) begin
								wbytes_q <= 8'd2; bidx_q <= '0; wcount_q <= '0;
								phase_q <= PH_D_HI;
							end else phase_q <= PH_WQ_HI;
						end
						PH_WQ_HI: phase_q <= PH_WQ_LO;
						PH_WQ_LO: phase_q <= PH_BCNT;
						PH_BCNT: begin
							wbytes_q <= b; bidx_q <= '0; wcount_q <= '0;
							phase_q <= PH_D_HI;
						end
						PH_D_HI: begin hold_q <= b; phase_q <= PH_D_LO; end
						PH_D_LO: begin
							bidx_q   <= bidx_q + 8'd2;
							wcount_q <= wcount_q + 8'd1;
							phase_q  <= (8'(bidx_q + 8'd2) == wbytes_q) ? PH_C_HI : PH_D_HI;
						end
						PH_C_HI: phase_q <= PH_C_LO;
						PH_C_LO: begin
							phase_q <= PH_IDLE;
							if (crc_nx == 16'h0000 && fcode_q == FC_READ_WRITE)
								job_valid_q <= 1'b1;
						end
						default: phase_q <= PH_IDLE;
					endcase
				end
			end
		end
	end

endmodule

// File: rtl/mrsfe_tx.sv
// Back part: register write sweep, then response bytes with CRC.
module mrsfe_tx #(
	parameter int REG_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_stall,
	input  mrsfe_pkg::job_t      job,
	output logic [3:0]           wb_addr,
	input  logic [15:0]          wb_data,
	input  logic [7:0]           slave_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mrsfe_pkg::out_beat_t out_data
);
	import mrsfe_pkg::*;

	localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_WRITE, S_HEAD, S_DATA, S_CRC_LO, S_CRC_HI
	} state_t;

	state_t      state_q;
	logic [15:0] regs_q [REG_COUNT];
	job_t        job_q;
	logic [4:0]  cnt_q, nw_q, nr_q;
	logic [1:0]  hcnt_q;
	logic        half_q;
	logic [15:0] crc_q;
	logic        ov_q;
	out_beat_t   od_q;

	logic [16:0] wlim, rend;
	logic [4:0]  nw, nr;
	logic [15:0] rval;
	logic [7:0]  nb;
	logic        send;
	logic        emit;

	assign job_stall = (state_q != S_IDLE);
	assign wb_addr   = cnt_q[3:0];
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign send      = !ov_q || !out_stall;
	assign emit      = send && (state_q == S_HEAD || state_q == S_DATA
	                            || state_q == S_CRC_LO || state_q == S_CRC_HI);

	// Word counts for the write and read parts.
	always_comb begin
		wlim = 17'(REG_COUNT) - {1'b0, job.write_start};
		if (job.write_start >= 16'(REG_COUNT)) nw = '0;
		else if ({9'd0, job.word_count} > wlim && wlim < 17'(WBUF_DEPTH)) nw = wlim[4:0];
		else if (job.word_count > 8'(WBUF_DEPTH)) nw = 5'(WBUF_DEPTH);
		else nw = job.word_count[4:0];
		rend = {1'b0, job.read_start} + {1'b0, job.read_quantity};
		if (rend > 17'(REG_COUNT)) rend = 17'(REG_COUNT);
		if (job.read_start >= 16'(REG_COUNT)) nr = '0;
		else if (17'(rend - {1'b0, job.read_start}) > 17'(RESP_WORDS)) nr = 5'(RESP_WORDS);
		else nr = 5'(rend - {1'b0, job.read_start});
	end

	assign rval = regs_q[RW'(job_q.read_start[RW-1:0] + RW'(cnt_q))];

	always_comb begin
		unique case (hcnt_q)
			2'd0:    nb = slave_id;
			2'd1:    nb = FC_READ_WRITE;
			default: nb = 8'(job_q.read_quantity << 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ov_q <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= '0;
			cnt_q <= '0; nw_q <= '0; nr_q <= '0; hcnt_q <= '0; half_q <= 1'b0;
			crc_q <= '0; od_q <= '0; job_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job; nw_q <= nw; nr_q <= nr; cnt_q <= '0;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (cnt_q == nw_q) begin
						cnt_q <= '0; hcnt_q <= '0; crc_q <= CRC_INIT; state_q <= S_HEAD;
					end else begin
						regs_q[RW'(job_q.write_start[RW-1:0] + RW'(cnt_q))] <= wb_data;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_HEAD: if (send) begin
					od_q <= '{tx_byte: nb, last_byte: 1'b0};
					crc_q <= crc_step(crc_q, nb);
					hcnt_q <= hcnt_q + 2'd1; half_q <= 1'b0;
					if (hcnt_q == 2'd2) state_q <= (nr_q == 5'd0) ? S_CRC_LO : S_DATA;
				end
				S_DATA: if (send) begin
					od_q <= '{tx_byte: half_q ? rval[7:0] : rval[15:8], last_byte: 1'b0};
					crc_q <= crc_step(crc_q, half_q ? rval[7:0] : rval[15:8]);
					half_q <= !half_q;
					if (half_q) begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q + 5'd1 == nr_q) state_q <= S_CRC_LO;
					end
				end
				S_CRC_LO: if (send) begin
					od_q <= '{tx_byte: crc_q[7:0], last_byte: 1'b0};
					state_q <= S_CRC_HI;
				end
				S_CRC_HI: if (send) begin
					od_q <= '{tx_byte: crc_q[15:8], last_byte: 1'b1};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/modbus_rtu_slave_frame_engine.sv
// Top level of the Modbus RTU slave frame engine.
//
//  channel | direction | beat            | handshake
//  in      | in        | in_beat_t       | in_valid / in_stall
//  out     | out       | out_beat_t      | out_valid / out_stall
//  cfg     | in        | index 3b, 8b    | cfg_we
//
// A good 0x17 frame hands one job to the response unit through a one-entry
// slot; the parser stalls while the slot is full. The response unit first
// writes the received words into its registers, then sends one response
// byte per cycle when out is not stalled. Reset clears all control state and
// the holding registers at once.
module modbus_rtu_slave_frame_engine #(
	parameter int REG_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mrsfe_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mrsfe_pkg::out_beat_t out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data
);
	import mrsfe_pkg::*;

	logic [7:0] slave_id_q, gap_start_q, gap_byte_q, idle_timeout_q, tick_ceiling_q;
	logic       timing_enable_q;
	logic       job_valid, job_stall;
	job_t       job;
	logic [3:0] wb_addr;
	logic [15:0] wb_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= 8'd1; timing_enable_q <= 1'b1; gap_start_q <= 8'd2;
			gap_byte_q <= 8'd1; idle_timeout_q <= 8'd10; tick_ceiling_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE_ID:      slave_id_q      <= cfg_data;
				REG_TIMING_ENABLE: timing_enable_q <= cfg_data[0];
				REG_GAP_START:     gap_start_q     <= cfg_data;
				REG_GAP_BYTE:      gap_byte_q      <= cfg_data;
				REG_IDLE_TIMEOUT:  idle_timeout_q  <= cfg_data;
				REG_TICK_CEILING:  tick_ceiling_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mrsfe_rx u_rx (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.slave_id(slave_id_q), .timing_enable(timing_enable_q),
		.gap_start(gap_start_q), .gap_byte(gap_byte_q),
		.idle_timeout(idle_timeout_q), .tick_ceiling(tick_ceiling_q),
		.job_valid, .job_stall, .job, .wb_addr, .wb_data
	);

	mrsfe_tx #(.REG_COUNT(REG_COUNT)) u_tx (
		.clk, .arst_n, .job_valid, .job_stall, .job, .wb_addr, .wb_data,
		.slave_id(slave_id_q), .out_valid, .out_stall, .out_data
	);

endmodule

// File: rtl/mrsfe_checker.sv
// Port-level checks for the frame engine.
module mrsfe_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input mrsfe_pkg::out_beat_t out_data,
	input logic                 out_valid,
	input logic                 out_stall
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out beat dropped");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last_byte |=> !out_valid || !out_data.last_byte)
		else $error("two last beats in a row");
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output during reset");
	a_in_open: assert property (@(posedge clk) !arst_n |=> !in_stall)
		else $error("input stalled right after reset");
endmodule

bind modbus_rtu_slave_frame_engine mrsfe_checker u_chk (
	.clk, .arst_n, .in_stall, .out_data, .out_valid, .out_stall
);

// File: verif/tb_top.sv
// Self-checking testbench for the Modbus RTU slave frame engine.
module tb_top;
	import mrsfe_pkg::*;

	localparam int REGS = 16;

	// Receiver phases, mirrored from the parser's frame walk.
	typedef enum logic [4:0] {
		P_IDLE, P_FCODE, P_RS_HI, P_RS_LO, P_RQ_HI, P_RQ_LO, P_WS_HI, P_WS_LO,
		P_WQ_HI, P_WQ_LO, P_BCNT, P_D_HI, P_D_LO, P_C_HI, P_C_LO
	} rx_phase_e;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_beat_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_beat_t  out_data;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_SLAVE_ID;
	logic [7:0] cfg_data = 8'h00;

	modbus_rtu_slave_frame_engine #(.REG_COUNT(REGS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow of the configuration registers (reset values).
	logic [7:0] sid = 8'd1;
	logic       t_en = 1'b1;
	logic [7:0] g_start = 8'd2;
	logic [7:0] g_byte = 8'd1;
	logic [7:0] idle_to = 8'd10;
	logic [7:0] t_ceil = 8'd255;

	// Shadow of the parser state.
	rx_phase_e   ph = P_IDLE;
	logic [15:0] crc_run = '0;
	logic [7:0]  ticks = '0;
	logic [7:0]  fcode = '0;
	logic [15:0] rd_start = '0, rd_qty = '0, wr_start = '0;
	logic [7:0]  wr_bytes = '0, b_idx = '0, w_cnt = '0, hi_hold = '0;
	logic [15:0] wbuf [WBUF_DEPTH];
	logic [15:0] hregs [REGS];

	out_beat_t   resp_q [$];     // response beats still owed by the block
	logic [7:0]  frm [$];        // frame under construction
	int          errors = 0;
	int          n_items = 0;
	int          n_resp = 0;
	int          n_frames = 0;
	bit          calm = 1'b0;    // no idling on either side

	function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
		return x;
	endfunction

	// Register writeback, then response bytes with trailing CRC.
	function automatic void build_response();
		int unsigned n, e;
		logic [15:0] c;
		logic [7:0]  rb [$];
		logic [15:0] q2;
		if (wr_start < REGS) begin
			n = w_cnt;
			if (n > REGS - wr_start) n = REGS - wr_start;
			if (n > WBUF_DEPTH) n = WBUF_DEPTH;
			for (int i = 0; i < n; i++) hregs[wr_start + i] = wbuf[i];
		end
		q2 = rd_qty * 2;
		rb.push_back(sid);
		rb.push_back(FC_READ_WRITE);
		rb.push_back(q2[7:0]);
		if (rd_start < REGS) begin
			e = rd_start + rd_qty;
			if (e > REGS) e = REGS;
			n = e - rd_start;
			if (n > RESP_WORDS) n = RESP_WORDS;
			for (int i = 0; i < n; i++) begin
				rb.push_back(hregs[rd_start + i][15:8]);
				rb.push_back(hregs[rd_start + i][7:0]);
			end
		end
		c = CRC_INIT;
		foreach (rb[k]) c = crc16_fold(c, rb[k]);
		crc_run = c;
		rb.push_back(c[7:0]);
		rb.push_back(c[15:8]);
		foreach (rb[k]) resp_q.push_back('{tx_byte: rb[k], last_byte: (k == rb.size() - 1)});
	endfunction

	// Advance the parser shadow by one accepted beat.
	function automatic void absorb(input in_beat_t bt);
		logic [7:0] b;
		b = bt.rx_byte;
		if (bt.req_type) begin
			if (ticks < t_ceil) ticks = ticks + 8'd1;
			else ticks = t_ceil;
			if (t_en && ph != P_IDLE && ticks > idle_to) ph = P_IDLE;
			return;
		end
		crc_run = crc16_fold(crc_run, b);
		if (ph == P_IDLE) begin
			if ((!t_en || ticks >= g_start) && b == sid) begin
				crc_run = crc16_fold(CRC_INIT, b);
				ph = P_FCODE;
			end
		end else if (t_en && ticks > g_byte) begin
			ph = P_IDLE;
		end else begin
			case (ph)
				P_FCODE: begin
					fcode = b;
					if (b == FC_READ_WRITE || b == FC_READ_HOLD) ph = P_RS_HI;
					else if (b == FC_WRITE_ONE || b == FC_WRITE_MULTI) ph = P_WS_HI;
					else ph = P_IDLE;
				end
				P_RS_HI: begin rd_start[15:8] = b; ph = P_RS_LO; end
				P_RS_LO: begin rd_start[7:0] = b; ph = P_RQ_HI; end
				P_RQ_HI: begin rd_qty[15:8] = b; ph = P_RQ_LO; end
				P_RQ_LO: begin
					rd_qty[7:0] = b;
					ph = (fcode == FC_READ_WRITE) ? P_WS_HI : P_C_HI;
				end
				P_WS_HI: begin wr_start[15:8] = b; ph = P_WS_LO; end
				P_WS_LO: begin
					wr_start[7:0] = b;
					// single write: exactly one data word, index realigned
					if (fcode == FC_WRITE_ONE) begin
						wr_bytes = 8'd2; b_idx = '0; w_cnt = '0;
						ph = P_D_HI;
					end else ph = P_WQ_HI;
				end
				P_WQ_HI: ph = P_WQ_LO;
				P_WQ_LO: ph = P_BCNT;
				P_BCNT: begin wr_bytes = b; b_idx = '0; w_cnt = '0; ph = P_D_HI; end
				P_D_HI: begin hi_hold = b; ph = P_D_LO; end
				P_D_LO: begin
					if (w_cnt < WBUF_DEPTH) wbuf[w_cnt] = {hi_hold, b};
					b_idx = b_idx + 8'd2;
					w_cnt = w_cnt + 8'd1;
					ph = (b_idx == wr_bytes) ? P_C_HI : P_D_HI;
				end
				P_C_HI: ph = P_C_LO;
				P_C_LO: begin
					ph = P_IDLE;
					if (crc_run == 16'h0000 && fcode == FC_READ_WRITE) build_response();
				end
				default: ph = P_IDLE;
			endcase
		end
		ticks = '0;
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 30) $display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Send one beat; valid stays up between back-to-back beats.
	task automatic put_beat(input logic is_tick, input logic [7:0] b);
		in_beat_t bt;
		bt = '{req_type: is_tick, rx_byte: b};
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= bt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		absorb(bt);
		n_items++;
	endtask

	task automatic put_ticks(input int n);
		repeat (n) put_beat(1'b1, 8'($urandom));
	endtask

	// Drain all owed responses, then let the response unit settle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (resp_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic poke(input logic [2:0] idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		case (idx)
			REG_SLAVE_ID:      sid = v;
			REG_TIMING_ENABLE: t_en = v[0];
			REG_GAP_START:     g_start = v;
			REG_GAP_BYTE:      g_byte = v;
			REG_IDLE_TIMEOUT:  idle_to = v;
			REG_TICK_CEILING:  t_ceil = v;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] id, input logic ten, input logic [7:0] gs,
			input logic [7:0] gb, input logic [7:0] it, input logic [7:0] tc);
		settle();
		poke(REG_SLAVE_ID, id);
		poke(REG_TIMING_ENABLE, {7'd0, ten});
		poke(REG_GAP_START, gs);
		poke(REG_GAP_BYTE, gb);
		poke(REG_IDLE_TIMEOUT, it);
		poke(REG_TICK_CEILING, tc);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add16(input logic [15:0] v);
		frm.push_back(v[15:8]);
		frm.push_back(v[7:0]);
	endtask

	task automatic add_crc(input bit spoil);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frm[k]) c = crc16_fold(c, frm[k]);
		if (spoil) c = c ^ 16'h0400;
		frm.push_back(c[7:0]);
		frm.push_back(c[15:8]);
	endtask

	// Read/write multiple frame: nw data words, bc as the byte count field.
	task automatic make_rw(input logic [7:0] id, input logic [15:0] rs, input logic [15:0] rq,
			input logic [15:0] ws, input int nw, input logic [7:0] bc, input bit spoil);
		frm.delete();
		frm.push_back(id);
		frm.push_back(FC_READ_WRITE);
		add16(rs); add16(rq); add16(ws);
		add16(16'(nw));
		frm.push_back(bc);
		repeat (nw) add16(16'($urandom));
		add_crc(spoil);
	endtask

	// Lead gap, then frame bytes; late_at > 0 puts a too-long gap before that byte.
	task automatic send_frame(input int late_at);
		int lead;
		lead = t_en ? ((g_start > 8) ? 8 : int'(g_start)) : $urandom_range(0, 2);
		put_ticks(lead);
		foreach (frm[k]) begin
			if (k > 0 && k == late_at) put_ticks(int'(g_byte) + 1);
			else if (k > 0 && t_en) put_ticks($urandom_range(0, (g_byte > 1) ? 1 : int'(g_byte)));
			put_beat(1'b0, frm[k]);
		end
		n_frames++;
	endtask

	// Random frame: mostly good read/write frames, some other codes and damage.
	task automatic rand_frame();
		int r, nw;
		logic [7:0] id;
		logic [15:0] rs, rq, ws;
		r  = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sid;
		rs = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 18));
		rq = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 18));
		ws = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 18));
		nw = $urandom_range(1, 18);
		if (r < 65) begin
			make_rw(id, rs, rq, ws, nw, 8'(2 * nw), $urandom_range(0, 9) == 0);
		end else begin
			frm.delete();
			frm.push_back(id);
			case ($urandom_range(0, 3))
				0: begin frm.push_back(FC_READ_HOLD); add16(rs); add16(rq); end
				1: begin frm.push_back(FC_WRITE_ONE); add16(ws); add16(16'($urandom)); end
				2: begin
					frm.push_back(FC_WRITE_MULTI); add16(ws); add16(16'(nw));
					frm.push_back(8'(2 * nw));
					repeat (nw) add16(16'($urandom));
				end
				default: frm.push_back(8'($urandom));
			endcase
			add_crc($urandom_range(0, 9) == 0);
		end
		send_frame(($urandom_range(0, 19) == 0) ? int'($urandom_range(1, frm.size() - 1)) : -1);
	endtask

	// Response checker.
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_resp++;
			if (resp_q.size() == 0) begin
				report($sformatf("unexpected beat tx=%02h last=%0b",
					out_data.tx_byte, out_data.last_byte));
			end else begin
				e = resp_q.pop_front();
				if (out_data.tx_byte !== e.tx_byte)
					report($sformatf("tx_byte %02h, want %02h", out_data.tx_byte, e.tx_byte));
				if (out_data.last_byte !== e.last_byte)
					report($sformatf("last_byte %0b, want %0b", out_data.last_byte, e.last_byte));
			end
		end
	end

	// Receiver backpressure in random bursts.
	always @(posedge clk) begin
		int hold;
		if (calm || !arst_n) begin
			hold = 0;
			out_stall <= 1'b0;
		end else if (hold > 0) begin
			hold--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			hold = $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Each protocol case once, at reset configuration.
	task automatic test_directed();
		make_rw(8'd1, 16'd0, 16'd16, 16'd0, 2, 8'd4, 1'b0); send_frame(-1);
		frm.delete(); frm.push_back(8'd1); frm.push_back(FC_READ_HOLD);
		add16(16'd2); add16(16'd3); add_crc(1'b0); send_frame(-1);
		// single write followed by a frame that must parse cleanly
		frm.delete(); frm.push_back(8'd1); frm.push_back(FC_WRITE_ONE);
		add16(16'd5); add16(16'hFFFF); add_crc(1'b0); send_frame(-1);
		frm.delete(); frm.push_back(8'd1); frm.push_back(FC_WRITE_MULTI);
		add16(16'd0); add16(16'd1); frm.push_back(8'd2); add16(16'h8001);
		add_crc(1'b0); send_frame(-1);
		frm.delete(); frm.push_back(8'd1); frm.push_back(8'hFF); add_crc(1'b0); send_frame(-1);
		make_rw(8'd1, 16'd0, 16'd4, 16'd1, 1, 8'd2, 1'b1); send_frame(-1);
		// start byte with no quiet gap in front
		put_beat(1'b0, 8'd1); put_beat(1'b0, FC_READ_WRITE);
		// late byte inside a frame
		make_rw(8'd1, 16'd0, 16'd2, 16'd0, 1, 8'd2, 1'b0); send_frame(5);
		// idle timeout mid-frame
		put_ticks(3); put_beat(1'b0, 8'd1); put_ticks(11); put_beat(1'b0, FC_READ_WRITE);
		// out-of-range window, more than sixteen words, wrapped byte count
		make_rw(8'd1, 16'd20, 16'd3, 16'd14, 4, 8'd8, 1'b0); send_frame(-1);
		make_rw(8'd1, 16'd0, 16'h00FF, 16'd0, 17, 8'd34, 1'b0); send_frame(-1);
		make_rw(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 8'd2, 1'b0); send_frame(-1);
		// odd byte count never ends by index; a late byte drops it
		frm.delete(); frm.push_back(8'd1); frm.push_back(FC_READ_WRITE);
		repeat (4) add16(16'd0);
		frm.push_back(8'd3); add16(16'h1234); add16(16'h5678);
		send_frame(-1); put_ticks(3); put_beat(1'b0, 8'h00);
	endtask

	// Register extremes, including timing off and a tiny tick ceiling.
	task automatic test_config_extremes();
		set_config(8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		rand_frame();
		set_config(8'd255, 1'b1, 8'd0, 8'd255, 8'd255, 8'd255);
		rand_frame();
		set_config(8'd7, 1'b1, 8'd255, 8'd0, 8'd0, 8'd3);
		rand_frame();
		set_config(8'd9, 1'b1, 8'd2, 8'd1, 8'd0, 8'd255);
		rand_frame();
	endtask

	// Random frames with line noise under several settings.
	task automatic test_random(input int target);
		int start;
		start = n_items;
		while (n_items - start < target) begin
			if ((n_items - start) % 120 < 8 && $urandom_range(0, 3) == 0)
				set_config(8'($urandom), $urandom_range(0, 3) != 0, 8'($urandom_range(0, 4)),
					8'($urandom_range(0, 3)), 8'($urandom_range(2, 20)),
					8'($urandom_range(3, 255)));
			if ($urandom_range(0, 9) == 0) put_beat(1'($urandom_range(0, 1)), 8'($urandom));
			else rand_frame();
		end
	endtask

	initial begin
		for (int i = 0; i < REGS; i++) hregs[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random(40);
		// closing stretch with no idling
		set_config(8'd1, 1'b1, 8'd2, 8'd1, 8'd10, 8'd255);
		calm = 1'b1;
		rand_frame();
		settle();
		$display("Covered %0d beats in %0d frames, %0d response beats checked.",
			n_items, n_frames, n_resp);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches.", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(12 * 1000000);
		$display("Timeout with %0d response beats outstanding.", resp_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
